// ===== hw/rtl/ldo_trim_pkg.sv =====
`timescale 1ns / 1ps

package ldo_trim_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 13;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] TARGET_RESET   = 13'd5405;
    localparam logic [LEVEL_W-1:0] WIN_LOW_RESET  = 13'd5159;
    localparam logic [LEVEL_W-1:0] WIN_HIGH_RESET = 13'd5651;

    localparam logic [CODE_W-1:0] UP_LIMIT   = 3'd3;
    localparam logic [CODE_W-1:0] DOWN_LIMIT = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET   = 2'd0,
        REG_WIN_LOW  = 2'd1,
        REG_WIN_HIGH = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_MEASURE = 2'd0,
        ACT_PASS    = 2'd1,
        ACT_FAIL    = 2'd2
    } action_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] target_level;
        logic [LEVEL_W-1:0] window_low;
        logic [LEVEL_W-1:0] window_high;
    } trim_cfg_t;

    typedef struct packed {
        action_t            action;
        logic [CODE_W-1:0]  trim_code;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] deviation;
    } trim_result_t;

    function automatic logic [CODE_W-1:0] code_for(input logic up, input logic [CODE_W-1:0] count);
        logic [CODE_W-1:0] down_code;
        down_code = CODE_W'(3'd0 - count);
        return up ? count : down_code;
    endfunction

endpackage

// ===== hw/rtl/ldo_trim_cfg.sv =====
`timescale 1ns / 1ps

module ldo_trim_cfg
    import ldo_trim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    output trim_cfg_t            cfg
);

    trim_cfg_t cfg_reg;
    trim_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:   cfg_next.target_level = cfg_data;
                REG_WIN_LOW:  cfg_next.window_low   = cfg_data;
                REG_WIN_HIGH: cfg_next.window_high  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level <= TARGET_RESET;
            cfg_reg.window_low   <= WIN_LOW_RESET;
            cfg_reg.window_high  <= WIN_HIGH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/ldo_trim_core.sv =====
`timescale 1ns / 1ps

module ldo_trim_core
    import ldo_trim_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [SAMPLE_W-1:0] sample,
    input  trim_cfg_t           cfg,
    output trim_result_t        result
);

    logic               searching_reg, searching_next;
    logic               step_up_reg, step_up_next;
    logic [CODE_W-1:0]  count_reg, count_next;
    logic [LEVEL_W-1:0] last_dev_reg;

    logic [LEVEL_W-1:0] level;
    logic               above;
    logic               below;
    logic [LEVEL_W-1:0] dev;
    logic [CODE_W-1:0]  limit;
    logic               in_window;
    action_t            action;
    logic [CODE_W-1:0]  code;

    assign level     = {sample, 1'b0};
    assign above     = level > cfg.target_level;
    assign below     = level < cfg.target_level;
    assign dev       = above ? (level - cfg.target_level) : (cfg.target_level - level);
    assign limit     = step_up_reg ? UP_LIMIT : DOWN_LIMIT;
    assign in_window = (level > cfg.window_low) && (level < cfg.window_high);

    always_comb
    begin
        step_up_next = step_up_reg;
        count_next   = count_reg;
        action       = ACT_FAIL;
        code         = '0;
        if (!searching_reg)
        begin
            step_up_next = below;
            count_next   = 3'd1;
            action       = ACT_MEASURE;
            code         = code_for(below, 3'd1);
        end
        else if (above != step_up_reg)
        begin
            if (count_reg < limit)
            begin
                count_next = count_reg + 3'd1;
                action     = ACT_MEASURE;
                code       = code_for(step_up_reg, count_reg + 3'd1);
            end
            else if (count_reg == limit && in_window)
            begin
                action = ACT_PASS;
                code   = code_for(step_up_reg, count_reg);
            end
        end
        else if (count_reg != 3'd0 && count_reg <= limit)
        begin
            action = ACT_PASS;
            code   = code_for(step_up_reg, (dev > last_dev_reg) ? count_reg - 3'd1 : count_reg);
        end
        searching_next = (action == ACT_MEASURE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            searching_reg <= 1'b0;
            step_up_reg   <= 1'b0;
            count_reg     <= '0;
            last_dev_reg  <= '0;
        end
        else if (step)
        begin
            searching_reg <= searching_next;
            step_up_reg   <= step_up_next;
            count_reg     <= count_next;
            last_dev_reg  <= dev;
        end
    end

    assign result.action    = action;
    assign result.trim_code = code;
    assign result.level     = level;
    assign result.deviation = dev;

endmodule

// ===== hw/rtl/ldo_trim_search_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Signals                                        | Dir
// sample   | sample_valid, sample_ready, adc_sample         | in
// result   | result_valid, result_ready, action, trim_code, | out
//          | level, deviation                               |
// config   | cfg_we, cfg_index, cfg_data                    | in
// One sample per cycle while the result side is not stalled; a result passes
// through the input register, then the decision logic into the result
// register, and is held there until result_ready takes it.
// Reset clears the search state and loads the default target and window.
// A stalled result holds the result register; the input register still takes
// one more beat, and sample_ready drops only when both are full.

module ldo_trim_search_unit
    import ldo_trim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic [SAMPLE_W-1:0]  adc_sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           action,
    output logic [CODE_W-1:0]    trim_code,
    output logic [LEVEL_W-1:0]   level,
    output logic [LEVEL_W-1:0]   deviation,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    trim_cfg_t     cfg;
    trim_result_t  core_result;
    trim_result_t  out_reg;
    logic          out_valid_reg;
    logic          in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic          advance;
    logic          take;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign take         = sample_valid && sample_ready;

    ldo_trim_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldo_trim_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_sample_reg <= adc_sample;
        if (advance)
            out_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign action       = out_reg.action;
    assign trim_code    = out_reg.trim_code;
    assign level        = out_reg.level;
    assign deviation    = out_reg.deviation;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ldo_trim_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic               searching;
        logic               step_up;
        logic [CODE_W-1:0]  step_count;
        logic [LEVEL_W-1:0] last_dev;
    } search_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    logic [SAMPLE_W-1:0]  adc_sample = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [1:0]           action;
    logic [CODE_W-1:0]    trim_code;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W-1:0]   deviation;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEVEL_W-1:0]   cfg_data = '0;

    logic [SAMPLE_W-1:0] pending_samples[$];
    trim_result_t        expected_results[$];
    trim_result_t        oldest_result;
    trim_cfg_t           active_cfg;
    search_state_t       search_model;
    search_state_t       plan_state;

    logic sample_taken = 1'b0;
    logic sender_steady = 1'b0;
    logic receiver_steady = 1'b0;
    logic pressure_done = 1'b0;
    int   send_gap = 0;
    int   ready_gap = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   pass_seen = 0;
    int   fail_seen = 0;
    int   settings_used = 1;

    ldo_trim_search_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .adc_sample   (adc_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .action       (action),
        .trim_code    (trim_code),
        .level        (level),
        .deviation    (deviation),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] step_code(input logic up, input logic [CODE_W-1:0] n);
        logic [3:0] wrapped;
        wrapped = 4'd8 - {1'b0, n};
        return up ? n : wrapped[CODE_W-1:0];
    endfunction

    function automatic trim_result_t trim_decide(inout search_state_t st, input trim_cfg_t c,
                                                 input logic [SAMPLE_W-1:0] s);
        trim_result_t       r;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] dev;
        logic [LEVEL_W-1:0] prev_dev;
        logic [CODE_W-1:0]  limit;
        logic               above;
        logic               prefer_prev;
        lvl = {s, 1'b0};
        above = lvl > c.target_level;
        dev = above ? lvl - c.target_level : c.target_level - lvl;
        prev_dev = st.last_dev;
        st.last_dev = dev;
        r.action = ACT_FAIL;
        r.trim_code = '0;
        r.level = lvl;
        r.deviation = dev;
        if (!st.searching)
        begin
            st.step_up = lvl < c.target_level;
            st.step_count = 3'd1;
            r.action = ACT_MEASURE;
            r.trim_code = step_code(st.step_up, st.step_count);
            st.searching = 1'b1;
        end
        else
        begin
            limit = st.step_up ? UP_LIMIT : DOWN_LIMIT;
            prefer_prev = dev > prev_dev;
            if (above != st.step_up)
            begin
                if (st.step_count < limit)
                begin
                    st.step_count = st.step_count + 3'd1;
                    r.action = ACT_MEASURE;
                    r.trim_code = step_code(st.step_up, st.step_count);
                end
                else if (st.step_count == limit && lvl > c.window_low && lvl < c.window_high)
                begin
                    r.action = ACT_PASS;
                    r.trim_code = step_code(st.step_up, st.step_count);
                end
            end
            else if (st.step_count >= 3'd1 && st.step_count <= limit)
            begin
                r.action = ACT_PASS;
                r.trim_code = step_code(st.step_up,
                                        prefer_prev ? st.step_count - 3'd1 : st.step_count);
            end
            if (r.action != ACT_MEASURE)
                st.searching = 1'b0;
        end
        if (r.action == ACT_FAIL)
            r.trim_code = '0;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // hold the beat until taken, then advance after the chosen gap
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!(sample_valid && !sample_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                sample_valid <= 1'b1;
                adc_sample <= pending_samples.pop_front();
                send_gap <= (sender_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!pressure_done && results_seen > 200 && pending_samples.size() > 20)
        begin
            pressure_done <= 1'b1;
            hold_left <= 60;
            result_ready <= 1'b0;
        end
        else if (receiver_steady)
            result_ready <= 1'b1;
        else if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        sample_taken <= rst_n && sample_valid && sample_ready;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: action %0d trim_code %0d",
                       action, trim_code);
                mismatch_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (oldest_result.action == ACT_PASS)
                    pass_seen++;
                if (oldest_result.action == ACT_FAIL)
                    fail_seen++;
                if (action !== oldest_result.action)
                begin
                    $error("action: expected %0d, got %0d", oldest_result.action, action);
                    mismatch_count++;
                end
                if (trim_code !== oldest_result.trim_code)
                begin
                    $error("trim_code: expected %0d, got %0d", oldest_result.trim_code, trim_code);
                    mismatch_count++;
                end
                if (level !== oldest_result.level)
                begin
                    $error("level: expected %0d, got %0d", oldest_result.level, level);
                    mismatch_count++;
                end
                if (deviation !== oldest_result.deviation)
                begin
                    $error("deviation: expected %0d, got %0d", oldest_result.deviation, deviation);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && sample_valid && sample_ready)
            expected_results.push_back(trim_decide(search_model, active_cfg, adc_sample));
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_TARGET:   active_cfg.target_level = value;
            REG_WIN_LOW:  active_cfg.window_low = value;
            REG_WIN_HIGH: active_cfg.window_high = value;
            default:      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input int tgt, input int lo, input int hi);
        write_reg(REG_TARGET, LEVEL_W'(tgt));
        write_reg(REG_WIN_LOW, LEVEL_W'(lo));
        write_reg(REG_WIN_HIGH, LEVEL_W'(hi));
        settings_used++;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        trim_result_t r;
        r = trim_decide(plan_state, active_cfg, s);
        pending_samples.push_back(s);
    endtask

    // mostly closed-loop searches against a linear regulator, with noise mixed in
    task automatic plan_searches(input int count);
        trim_result_t       r;
        logic [SAMPLE_W-1:0] s;
        int base_lvl;
        int step_sz;
        int offset;
        int v;
        int pick;
        logic [CODE_W-1:0] cur_code;
        base_lvl = 0;
        step_sz = 0;
        cur_code = '0;
        for (int i = 0; i < count; i++)
        begin
            if (!plan_state.searching)
            begin
                base_lvl = int'(active_cfg.target_level) + int'($urandom_range(0, 600)) - 300;
                step_sz = $urandom_range(10, 150);
                cur_code = '0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                s = SAMPLE_W'($urandom_range(0, 4095));
            else if (pick < 10)
                s = ($urandom_range(0, 1) == 1) ? '1 : '0;
            else
            begin
                offset = (cur_code >= 3'd4) ? int'(cur_code) - 8 : int'(cur_code);
                v = base_lvl + step_sz * offset + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
                if (v > 8190)
                    v = 8190;
                s = SAMPLE_W'(v / 2);
            end
            r = trim_decide(plan_state, active_cfg, s);
            cur_code = r.trim_code;
            pending_samples.push_back(s);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int tgt;
        active_cfg.target_level = TARGET_RESET;
        active_cfg.window_low = WIN_LOW_RESET;
        active_cfg.window_high = WIN_HIGH_RESET;
        search_model = '{1'b0, 1'b0, 3'd0, 13'd0};
        plan_state = search_model;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_sample(12'd0);
        queue_sample(12'd4095);
        repeat (5) queue_sample(12'd4095);
        repeat (5) queue_sample(12'd2800);
        repeat (4) queue_sample(12'd2000);
        repeat (4) queue_sample(12'd2650);
        queue_sample(12'd2750);
        queue_sample(12'd2690);
        wait_idle();

        load_settings(5400, WIN_LOW_RESET, WIN_HIGH_RESET);
        queue_sample(12'd2700);
        queue_sample(12'd2700);
        plan_searches(40);
        wait_idle();

        for (int ph = 0; ph < 11; ph++)
        begin
            case (ph)
                0: load_settings(0, 0, 8191);
                1: load_settings(8191, 0, 8191);
                2: load_settings(8191, 8191, 0);
                3: load_settings(0, 8191, 8191);
                4:
                begin
                    write_reg(REG_SPARE, LEVEL_W'($urandom_range(0, 8191)));
                    load_settings(TARGET_RESET, WIN_LOW_RESET, WIN_HIGH_RESET);
                end
                default:
                begin
                    tgt = $urandom_range(1000, 7000);
                    load_settings(tgt, tgt - int'($urandom_range(0, 400)),
                                  tgt + int'($urandom_range(0, 400)));
                end
            endcase
            sender_steady = (ph % 4 == 1);
            receiver_steady = (ph % 4 == 2);
            plan_searches(100);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            mismatch_count++;
        $display("covered %0d results under %0d register settings", results_seen, settings_used);
        $display("verdicts seen: %0d pass, %0d fail", pass_seen, fail_seen);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ldo_trim_pkg.sv
hw/rtl/ldo_trim_cfg.sv
hw/rtl/ldo_trim_core.sv
hw/rtl/ldo_trim_search_unit.sv
tb/tb_top.sv
